### design/gcc_pkg.sv
// ----------------------------------------------------------------------------
// gcc_pkg
// Shared types, constants and the corner classification function of the
// grid corner classifier.
// ----------------------------------------------------------------------------
package gcc_pkg;

  localparam int GCC_MAX_WIDTH  = 1024;
  localparam int GCC_MAX_HEIGHT = 1024;

  localparam int GCC_CFG_W     = 11;
  localparam int GCC_CFG_IDX_W = 1;

  localparam logic [GCC_CFG_IDX_W-1:0] GCC_CFG_GRID_WIDTH  = 1'b0;
  localparam logic [GCC_CFG_IDX_W-1:0] GCC_CFG_GRID_HEIGHT = 1'b1;

  localparam logic [GCC_CFG_W-1:0] GCC_GRID_WIDTH_RST  = 11'd64;
  localparam logic [GCC_CFG_W-1:0] GCC_GRID_HEIGHT_RST = 11'd64;

  localparam logic [4:0] GCC_CODE_TOP   = 5'd1;
  localparam logic [4:0] GCC_CODE_BOT   = 5'd2;
  localparam logic [4:0] GCC_CODE_LEFT  = 5'd4;
  localparam logic [4:0] GCC_CODE_RIGHT = 5'd8;
  localparam logic [4:0] GCC_CODE_TL    = 5'd5;
  localparam logic [4:0] GCC_CODE_BR    = 5'd10;
  localparam logic [4:0] GCC_CODE_TR    = 5'd9;
  localparam logic [4:0] GCC_CODE_BL    = 5'd6;
  localparam logic [4:0] GCC_CODE_MAX   = 5'd30;

  typedef struct packed {
    logic kind;
    logic is_wall;
  } gcc_in_t;

  typedef struct packed {
    logic [4:0] corner_code;
    logic [9:0] cell_x;
    logic [9:0] cell_y;
    logic       frame_last;
  } gcc_out_t;

  // column bits: [0] top, [1] middle, [2] bottom
  typedef struct packed {
    logic col;
    logic top;
    logic bot;
  } gcc_force_t;

  // window: right column [2:0], centre [5:3], left [8:6]
  function automatic logic [4:0] gcc_classify(input logic [8:0] w);
    logic [4:0] code;
    code = '0;
    if (!w[4]) begin
      if (w[7]) code = code + GCC_CODE_LEFT;
      if (w[1]) code = code + GCC_CODE_RIGHT;
      if (w[3]) code = code + GCC_CODE_TOP;
      if (w[5]) code = code + GCC_CODE_BOT;
      if (code == '0) begin
        if (w[6]) code = code + GCC_CODE_TL;
        if (w[2]) code = code + GCC_CODE_BR;
        if (w[0]) code = code + GCC_CODE_TR;
        if (w[8]) code = code + GCC_CODE_BL;
      end
      if (code == GCC_CODE_TOP || code == GCC_CODE_BOT ||
          code == GCC_CODE_LEFT || code == GCC_CODE_RIGHT) begin
        code = '0;
      end
    end
    return code;
  endfunction

endpackage

### design/grid_corner_classifier.sv
// ----------------------------------------------------------------------------
// grid_corner_classifier
// Raster stream of wall cells in, one corner code per classified cell out.
//
//   port group   dir  beat                 accepted when
//   in_*         in   gcc_in_t  (cell)     in_valid_i & !in_stall_o
//   out_*        out  gcc_out_t (result)   out_valid_o & !out_stall_i
//   cfg_*        in   register write       cfg_we_i
//
// One input beat per cycle unless stalled; a result passes s1 and the
// output register after its triggering beat, one row plus one cell on.
// The line buffers sit in one two-bit RAM, read on accept and written when
// s1 fires, with a bypass for back-to-back beats on the same column.
// Reset clears position and fill count, window to walls; no clearing pass.
// A stalled result stalls the input in the same cycle.
// ----------------------------------------------------------------------------
module grid_corner_classifier
  import gcc_pkg::*;
#(
  parameter int MAX_WIDTH  = GCC_MAX_WIDTH,
  parameter int MAX_HEIGHT = GCC_MAX_HEIGHT
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  gcc_in_t                  in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output gcc_out_t                 out_data_o,
  input  logic                     cfg_we_i,
  input  logic [GCC_CFG_IDX_W-1:0] cfg_index_i,
  input  logic [GCC_CFG_W-1:0]     cfg_data_i
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);

  logic [GCC_CFG_W-1:0] wid_q, hgt_q;
  logic [WW-1:0]        eff_w, w_last;
  logic [HW-1:0]        eff_h;
  logic [RW-1:0]        h_last;

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [WW-1:0] fill_q, fill_d;

  logic          hold, in_accept, s1_fire;
  logic          col_wrap;
  logic [CW-1:0] cx, tx;
  logic [RW-1:0] ry, ty;
  logic          cur_wall, res, last;
  logic          f_left, f_right, f_top, f_bot;

  logic          s1_valid_q, s1_cell_q, s1_res_q, s1_last_q;
  logic          s1_fwd_q, s1_unwr_q;
  logic [1:0]    s1_fwd_bits_q;
  logic [CW-1:0] s1_cx_q, s1_tx_q;
  logic [RW-1:0] s1_ty_q;
  logic [3:0]    s1_force_q;

  logic [1:0]    rd_data, am, wr_data;

  logic          out_valid_q;
  logic [CW-1:0] out_x_q;
  logic [RW-1:0] out_y_q;
  logic          out_last_q;
  logic [3:0]    out_force_q;

  gcc_force_t    cell_force [3];
  logic [2:0]    cell_col [3];
  logic [2:0]    cell_view [3];
  logic [8:0]    window;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wid_q <= GCC_GRID_WIDTH_RST;
      hgt_q <= GCC_GRID_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        GCC_CFG_GRID_WIDTH:  wid_q <= cfg_data_i;
        GCC_CFG_GRID_HEIGHT: hgt_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (wid_q == '0) begin
      eff_w = WW'(1);
    end else if (int'(wid_q) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(wid_q);
    end
    if (hgt_q == '0) begin
      eff_h = HW'(1);
    end else if (int'(hgt_q) > MAX_HEIGHT) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(hgt_q);
    end
    w_last = eff_w - 1'b1;
    h_last = RW'(eff_h - 1'b1);
  end

  // handshake
  assign hold       = out_valid_q && out_stall_i;
  assign in_stall_o = hold;
  assign in_accept  = in_valid_i && !hold;
  assign s1_fire    = s1_valid_q && !hold;

  // raster position and result target
  always_comb begin
    col_wrap = WW'(col_q) >= eff_w;
    cx       = col_wrap ? '0 : col_q;
    ry       = col_wrap ? row_q + 1'b1 : row_q;
    cur_wall = (ry >= RW'(eff_h)) ? 1'b1 : (in_data_i.kind | in_data_i.is_wall);
    if (cx != '0) begin
      res = (ry != '0);
      tx  = cx - 1'b1;
      ty  = ry - 1'b1;
    end else begin
      res = (ry >= RW'(2));
      tx  = CW'(w_last);
      ty  = ry - RW'(2);
    end
    f_left  = (tx == '0);
    f_right = (WW'(tx) >= w_last);
    f_top   = (ty == '0);
    f_bot   = (ty >= h_last);
    last    = res && f_right && f_bot;

    col_d = col_q;
    row_d = row_q;
    if (in_accept) begin
      if (last) begin
        col_d = '0;
        row_d = '0;
      end else if (WW'(cx) + 1'b1 >= eff_w) begin
        col_d = '0;
        row_d = ry + 1'b1;
      end else begin
        col_d = cx + 1'b1;
        row_d = ry;
      end
    end
  end

  // line buffer: bit 0 row above, bit 1 middle row
  gcc_ram #(
    .WIDTH(2),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk_i    (clk_i),
    .wr_en_i  (s1_fire),
    .wr_addr_i(s1_cx_q),
    .wr_data_i(wr_data),
    .rd_en_i  (in_accept),
    .rd_addr_i(cx),
    .rd_data_o(rd_data)
  );

  always_comb begin
    if (s1_fwd_q) begin
      am = s1_fwd_bits_q;
    end else if (s1_unwr_q) begin
      am = 2'b11;
    end else begin
      am = rd_data;
    end
    wr_data = {s1_cell_q, am[1]};
    fill_d  = fill_q;
    if (s1_fire && (WW'(s1_cx_q) + 1'b1 > fill_q)) begin
      fill_d = WW'(s1_cx_q) + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      fill_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      fill_q <= fill_d;
      if (!hold) begin
        s1_valid_q  <= in_accept;
        out_valid_q <= s1_fire && s1_res_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_cx_q       <= cx;
      s1_cell_q     <= cur_wall;
      s1_res_q      <= res;
      s1_tx_q       <= tx;
      s1_ty_q       <= ty;
      s1_last_q     <= last;
      s1_force_q    <= {f_left, f_right, f_top, f_bot};
      s1_fwd_q      <= s1_fire && (s1_cx_q == cx);
      s1_fwd_bits_q <= wr_data;
      s1_unwr_q     <= WW'(cx) >= fill_q;
    end
    if (s1_fire) begin
      out_x_q     <= s1_tx_q;
      out_y_q     <= s1_ty_q;
      out_last_q  <= s1_last_q;
      out_force_q <= s1_force_q;
    end
  end

  // window chain: cell 0 right column, cell 2 left column
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cell_force[k].top = out_force_q[1];
      cell_force[k].bot = out_force_q[0];
      cell_force[k].col = 1'b0;
    end
    cell_force[0].col = out_force_q[2];
    cell_force[2].col = out_force_q[3];
  end

  for (genvar k = 0; k < 3; k++) begin : g_cell
    gcc_window_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(s1_fire),
      .col_i  ((k == 0) ? {s1_cell_q, am[1], am[0]} : cell_col[(k == 0) ? 0 : k - 1]),
      .force_i(cell_force[k]),
      .col_o  (cell_col[k]),
      .view_o (cell_view[k])
    );
    assign window[3*k +: 3] = cell_view[k];
  end

  assign out_valid_o            = out_valid_q;
  assign out_data_o.corner_code = gcc_classify(window);
  assign out_data_o.cell_x      = 10'(out_x_q);
  assign out_data_o.cell_y      = 10'(out_y_q);
  assign out_data_o.frame_last  = out_last_q;

  // checks
  a_code_legal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.corner_code != GCC_CODE_TOP &&
                     out_data_o.corner_code != GCC_CODE_BOT &&
                     out_data_o.corner_code != GCC_CODE_LEFT &&
                     out_data_o.corner_code != GCC_CODE_RIGHT &&
                     out_data_o.corner_code <= GCC_CODE_MAX))
    else $error("illegal corner code");

  a_frame_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && last) |=> (col_q == '0 && row_q == '0))
    else $error("position not reset after frame end");

  a_fill_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> (fill_q > WW'($past(s1_cx_q))))
    else $error("fill count misses written column");

  a_last_corner : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.frame_last) |-> (out_force_q[2] && out_force_q[0]))
    else $error("frame end away from bottom right");

endmodule

### design/gcc_ram.sv
// ----------------------------------------------------------------------------
// gcc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gcc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### design/gcc_window_cell.sv
// ----------------------------------------------------------------------------
// gcc_window_cell
// One column of the 3x3 neighborhood window: holds three cells, hands them to
// the next column on each shift and shows them with edge walls forced in.
// ----------------------------------------------------------------------------
module gcc_window_cell
  import gcc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       shift_i,
  input  logic [2:0] col_i,
  input  gcc_force_t force_i,
  output logic [2:0] col_o,
  output logic [2:0] view_o
);

  logic [2:0] col_q;
  logic [2:0] col_d;

  assign col_d = shift_i ? col_i : col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '1;
    end else begin
      col_q <= col_d;
    end
  end

  assign col_o  = col_q;
  assign view_o = col_q | {force_i.bot | force_i.col, force_i.col, force_i.top | force_i.col};

endmodule
